@@ rtl/spq_pkg.sv @@
// Shared types and constants for the sorted priority queue.
package spq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int VALUE_W        = 32;
   localparam int ERR_W          = 2;

   typedef enum logic [0:0] {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE  = 2'd0,
      ERR_EMPTY = 2'd1,
      ERR_FULL  = 2'd2
   } err_type;

   typedef struct packed {
      logic enq;
      logic deq;
   } cell_ctrl_type;

endpackage

@@ rtl/spq_cell.sv @@
// One cell of the sorted chain: holds one entry and shifts toward its neighbors.
module spq_cell import spq_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  cell_ctrl_type         ctrl,
   input  logic [DATA_WIDTH-1:0] new_value,
   input  logic                  occupied,
   input  logic                  prev_keep,
   input  logic [DATA_WIDTH-1:0] prev_value,
   input  logic [DATA_WIDTH-1:0] next_value,
   output logic                  keep,
   output logic [DATA_WIDTH-1:0] value
);

   logic [DATA_WIDTH-1:0] value_ff;
   logic [DATA_WIDTH-1:0] value_in;

   assign keep  = occupied && ($signed(value_ff) <= $signed(new_value));
   assign value = value_ff;

   always_comb begin
      value_in = value_ff;
      if (ctrl.enq && !keep) begin
         value_in = prev_keep ? new_value : prev_value;
      end else if (ctrl.deq) begin
         value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

@@ rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue built as a chain of compare cells.
// The result of an item is valid in the cycle after its transfer.
// One item per cycle while no result waits unaccepted; all cells compare against the new value at once.
// The single output register stalls the input only while a result waits unaccepted.
// Reset clears the fill count, the output valid and the error code; cell contents are not cleared.
module sorted_priority_queue import spq_pkg::*; #(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int CNT_W      = $clog2(DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [VALUE_W-1:0] rsp_head_value,
   output logic               rsp_is_empty,
   output logic [CNT_W-1:0]   rsp_fill_count,
   output logic [ERR_W-1:0]   rsp_error_code
);

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   err_type               err_ff;
   err_type               err_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  accept;
   logic                  full;
   logic                  empty;
   cell_ctrl_type         ctrl;
   logic [DATA_WIDTH-1:0] new_value;
   logic [VALUE_W-1:0]    head_ext;
   logic [DATA_WIDTH-1:0] cell_value [DEPTH];
   logic                  cell_keep [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign empty     = (count_ff == '0);

   generate
      if (DATA_WIDTH <= VALUE_W) begin : g_narrow
         assign new_value = req_value[DATA_WIDTH-1:0];
         assign head_ext  = {{(VALUE_W - DATA_WIDTH){cell_value[0][DATA_WIDTH-1]}},
                             cell_value[0]};
      end else begin : g_wide
         assign new_value = {{(DATA_WIDTH - VALUE_W){1'b0}}, req_value};
         assign head_ext  = cell_value[0][VALUE_W-1:0];
      end
   endgenerate

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                  prev_keep;
         logic [DATA_WIDTH-1:0] prev_value;
         logic [DATA_WIDTH-1:0] next_value;

         if (i == 0) begin : g_first
            assign prev_keep  = 1'b1;
            assign prev_value = '0;
         end else begin : g_inner
            assign prev_keep  = cell_keep[i-1];
            assign prev_value = cell_value[i-1];
         end

         if (i == DEPTH - 1) begin : g_last
            assign next_value = '0;
         end else begin : g_more
            assign next_value = cell_value[i+1];
         end

         spq_cell #(
            .DATA_WIDTH(DATA_WIDTH)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .new_value  (new_value),
            .occupied   (CNT_W'(i) < count_ff),
            .prev_keep  (prev_keep),
            .prev_value (prev_value),
            .next_value (next_value),
            .keep       (cell_keep[i]),
            .value      (cell_value[i])
         );
      end
   endgenerate

   always_comb begin
      ctrl         = '0;
      count_in     = count_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         err_in       = ERR_NONE;
         if (op_type'(req_operation) == OP_ENQUEUE) begin
            if (full) begin
               err_in = ERR_FULL;
            end else begin
               ctrl.enq = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            if (empty) begin
               err_in = ERR_EMPTY;
            end else begin
               ctrl.deq = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         err_ff       <= ERR_NONE;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         err_ff       <= err_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_head_value = empty ? '0 : head_ext;
   assign rsp_is_empty   = empty;
   assign rsp_fill_count = count_ff;
   assign rsp_error_code = err_ff;

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("Fill count exceeds the queue depth.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && err_ff == ERR_FULL |-> full)
      else $error("Full error reported while the queue is not full.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && err_ff == ERR_EMPTY |-> empty)
      else $error("Empty error reported while the queue holds entries.");

   assert property (@(posedge clock) disable iff (reset)
      accept && op_type'(req_operation) == OP_DEQUEUE && !empty
      |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("Dequeue transfer did not lower the fill count.");

   assert property (@(posedge clock) disable iff (reset)
      count_ff >= CNT_W'(2) |-> $signed(cell_value[0]) <= $signed(cell_value[1]))
      else $error("Head of the chain is out of order.");

endmodule
